### design/chtp_pkg.sv
// Package for the clustered hash table probe/replace block.
// Holds the table geometry, the transaction codes and the payload and row types.
// No dependencies.
package chtp_pkg;

   localparam int CLUSTERS = 4096;
   localparam int WAYS     = 4;
   localparam int CL_W     = $clog2(CLUSTERS);
   localparam int LANE_W   = $clog2(WAYS);
   localparam int SCORE_W  = 17;

   typedef enum logic [1:0] {
      KIND_PROBE      = 2'd0,
      KIND_SAVE       = 2'd1,
      KIND_NEW_SEARCH = 2'd2,
      KIND_UNUSED     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        cluster_index;
      logic [31:0]        key_tag;
      logic [15:0]        new_move;
      logic signed [15:0] new_score;
      logic signed [15:0] new_eval;
      logic signed [15:0] new_depth;
      logic [1:0]         new_bound;
      logic               new_pv;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [1:0]         lane;
      logic [15:0]        found_move;
      logic signed [15:0] found_score;
      logic signed [15:0] found_eval;
      logic signed [15:0] found_depth;
      logic [7:0]         found_age;
      logic [1:0]         found_bound;
      logic               found_pv;
      logic               written;
   } rsp_type;

   // One lane of a cluster; flag holds the bound in bits 1..0 and pv in bit 2.
   typedef struct packed {
      logic [31:0] tag;
      logic [15:0] move;
      logic [15:0] score;
      logic [15:0] eval;
      logic [15:0] depth;
      logic [7:0]  age;
      logic [2:0]  flag;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

endpackage

### design/cluster_hash_table_probe_replace.sv
// Four-way clustered hash table with depth/age replacement, top level.
// Depends on chtp_pkg for types and geometry.
//
// After reset the block sweeps all 4096 rows (CLUSTERS) of the cluster memory,
// one row per cycle, and accepts no transaction meanwhile; csr writes are
// taken at any time. All four lanes of a cluster sit in one row of a single
// synchronous memory, so a probe or save is one row read and at most one row
// write. A probe or save passes through accept and read, lane metrics, lane
// choice and write back, and result; a new-search or unused code goes from
// acceptance straight to the result. One transaction is in flight at a time,
// and the next one is accepted once the result has moved into the output register.
module cluster_hash_table_probe_replace (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  chtp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chtp_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [chtp_pkg::CL_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [7:0]                      gen_ff, gen_in;
   logic [1:0]                      exact_ff, exact_in;
   chtp_pkg::req_type               req_ff, req_in;
   chtp_pkg::rsp_type               res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   chtp_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   chtp_pkg::row_type               mem [chtp_pkg::CLUSTERS];
   chtp_pkg::row_type               rd_row_ff;
   logic                            mem_re;
   logic [chtp_pkg::CL_W-1:0]       mem_raddr;
   logic                            mem_we;
   logic [chtp_pkg::CL_W-1:0]       mem_waddr;
   chtp_pkg::row_type               mem_wdata;

   logic [chtp_pkg::WAYS-1:0]       live_ff, live_in;
   logic [chtp_pkg::WAYS-1:0]       match_ff, match_in;
   logic signed [chtp_pkg::SCORE_W-1:0] score_ff [chtp_pkg::WAYS];
   logic signed [chtp_pkg::SCORE_W-1:0] score_in [chtp_pkg::WAYS];

   logic                            req_fire;
   logic                            out_load;

   // Lane choice signals
   logic                            sel_hit;
   logic                            sel_empty;
   logic [chtp_pkg::LANE_W-1:0]     match_lane;
   logic [chtp_pkg::LANE_W-1:0]     empty_lane;
   logic [chtp_pkg::LANE_W-1:0]     min01, min23, min_lane;
   logic [chtp_pkg::LANE_W-1:0]     lane_sel;
   chtp_pkg::entry_type             ent;
   chtp_pkg::entry_type             new_ent;
   logic                            weaker;
   logic                            do_write;
   chtp_pkg::row_type               wrow;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign out_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign mem_re    = req_fire && (req_payload.kind == chtp_pkg::KIND_PROBE ||
                                   req_payload.kind == chtp_pkg::KIND_SAVE);
   assign mem_raddr = req_payload.cluster_index[chtp_pkg::CL_W-1:0];

   // Per-lane liveness, tag match and replacement score from the row just read.
   always_comb begin
      logic [7:0]                      gap;
      logic signed [chtp_pkg::SCORE_W-1:0] s;
      for (int i = 0; i < chtp_pkg::WAYS; i++) begin
         gap         = gen_ff - rd_row_ff[i].age;
         live_in[i]  = (rd_row_ff[i].age != 8'd0);
         match_in[i] = live_in[i] && (rd_row_ff[i].tag == req_ff.key_tag);
         s = $signed({rd_row_ff[i].depth[15], rd_row_ff[i].depth})
             - $signed({8'd0, gap, 1'b0});
         if (rd_row_ff[i].flag[1:0] == exact_ff) begin
            s = s + 17'sd8;
         end
         if (rd_row_ff[i].flag[2]) begin
            s = s + 17'sd4;
         end
         score_in[i] = s;
      end
   end

   // Lane choice: first live match, else first empty lane, else lowest score.
   always_comb begin
      sel_hit    = 1'b0;
      sel_empty  = 1'b0;
      match_lane = '0;
      empty_lane = '0;
      for (int i = chtp_pkg::WAYS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            sel_hit    = 1'b1;
            match_lane = chtp_pkg::LANE_W'(i);
         end
         if (!live_ff[i]) begin
            sel_empty  = 1'b1;
            empty_lane = chtp_pkg::LANE_W'(i);
         end
      end
      min01    = (score_ff[1] < score_ff[0]) ? 2'd1 : 2'd0;
      min23    = (score_ff[3] < score_ff[2]) ? 2'd3 : 2'd2;
      min_lane = (score_ff[min23] < score_ff[min01]) ? min23 : min01;
      priority if (sel_hit) begin
         lane_sel = match_lane;
      end else if (sel_empty) begin
         lane_sel = empty_lane;
      end else begin
         lane_sel = min_lane;
      end
   end

   always_comb begin
      ent    = rd_row_ff[lane_sel];
      weaker = sel_hit
               && (req_ff.new_depth < $signed(ent.depth))
               && (req_ff.new_bound != exact_ff)
               && (ent.flag[1:0] == exact_ff)
               && !req_ff.new_pv
               && ent.flag[2];
      do_write = (req_ff.kind == chtp_pkg::KIND_SAVE) && !weaker;

      new_ent.tag   = req_ff.key_tag;
      new_ent.move  = (sel_hit && req_ff.new_move == 16'd0) ? ent.move : req_ff.new_move;
      new_ent.score = req_ff.new_score;
      new_ent.eval  = req_ff.new_eval;
      new_ent.depth = req_ff.new_depth;
      new_ent.age   = gen_ff;
      new_ent.flag  = {req_ff.new_pv, req_ff.new_bound};

      wrow           = rd_row_ff;
      wrow[lane_sel] = new_ent;
   end

   // Memory port control: clearing sweep after reset, write back in EVAL.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_EVAL) begin
         mem_we    = do_write;
         mem_waddr = req_ff.cluster_index[chtp_pkg::CL_W-1:0];
         mem_wdata = wrow;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      gen_in       = gen_ff;
      exact_in     = exact_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         exact_in = csr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == chtp_pkg::CL_W'(chtp_pkg::CLUSTERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_payload;
               res_in = '0;
               if (mem_re) begin
                  state_in = ST_READ;
               end else begin
                  if (req_payload.kind == chtp_pkg::KIND_NEW_SEARCH) begin
                     // advance generation, skipping zero
                     gen_in = (gen_ff == 8'hFF) ? 8'd1 : gen_ff + 8'd1;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            res_in.hit     = sel_hit;
            res_in.lane    = lane_sel;
            res_in.written = do_write;
            if (sel_hit) begin
               res_in.found_move  = ent.move;
               res_in.found_score = ent.score;
               res_in.found_eval  = ent.eval;
               res_in.found_depth = ent.depth;
               res_in.found_age   = ent.age;
               res_in.found_bound = ent.flag[1:0];
               res_in.found_pv    = ent.flag[2];
            end else begin
               res_in.found_move  = '0;
               res_in.found_score = '0;
               res_in.found_eval  = '0;
               res_in.found_depth = '0;
               res_in.found_age   = '0;
               res_in.found_bound = '0;
               res_in.found_pv    = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         gen_ff       <= 8'd1;
         exact_ff     <= 2'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         gen_ff       <= gen_in;
         exact_ff     <= exact_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      live_ff     <= live_in;
      match_ff    <= match_in;
      for (int i = 0; i < chtp_pkg::WAYS; i++) begin
         score_ff[i] <= score_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= mem[mem_raddr];
      end
   end

endmodule

### design/chtp_checker.sv
// Port-level checker for cluster_hash_table_probe_replace, with its bind.
// Depends on chtp_pkg for the payload types.
module chtp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input chtp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input chtp_pkg::rsp_type rsp_payload,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // one transaction in flight: ready drops right after acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while another is in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |->
         rsp_payload.found_move == 16'd0 && rsp_payload.found_age == 8'd0 &&
         rsp_payload.found_depth == 16'sd0 && rsp_payload.found_pv == 1'b0)
      else $error("miss result carries stored fields");

   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |-> rsp_payload.found_age != 8'd0)
      else $error("hit reported on an empty lane");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

endmodule

bind cluster_hash_table_probe_replace chtp_checker u_chtp_checker (.*);

### tb/tb_cluster_hash_table_probe_replace.sv
// Self-checking testbench for cluster_hash_table_probe_replace: predicts every lookup
// response from a local copy of the cluster table and compares it field by field.
// Depends on chtp_pkg and the block's top level only.
module tb_cluster_hash_table_probe_replace;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 800_000;
   localparam int HOT_CLUSTERS = 6;
   localparam int TAG_POOL     = 10;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   chtp_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   chtp_pkg::rsp_type rsp_payload;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_data;

   // Local copy of the table and of the generation and exact-bound registers
   chtp_pkg::entry_type tt_entry [chtp_pkg::CLUSTERS][chtp_pkg::WAYS];
   logic [7:0]          tt_generation;
   logic [1:0]          tt_exact_code;

   chtp_pkg::rsp_type lookups_due[$];
   chtp_pkg::rsp_type want;
   string             diffs;

   int mismatches = 0;
   int rsp_checked = 0;
   int items_sent = 0;
   int hits_seen = 0;
   int entries_written = 0;
   int saves_skipped = 0;
   int evictions = 0;
   int generation_wraps = 0;

   bit sender_idle_en = 1'b0;
   bit rsp_stall_en = 1'b0;
   int burst_left = 1;
   int stall_left = 0;
   int run_left = 0;

   int          hot_cl [HOT_CLUSTERS];
   logic [31:0] tag_pool [TAG_POOL];

   always #1 clock = ~clock;

   cluster_hash_table_probe_replace u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic int replace_rank(chtp_pkg::entry_type e);
      logic [7:0] gap;
      int         rank;
      gap  = tt_generation - e.age;
      rank = $signed(e.depth);
      rank = rank - 2 * int'(gap);
      if (e.flag[1:0] == tt_exact_code) rank += 8;
      if (e.flag[2]) rank += 4;
      return rank;
   endfunction

   // Compute the response for one transaction and apply it to the table copy
   function automatic chtp_pkg::rsp_type probe_table(chtp_pkg::req_type r);
      chtp_pkg::rsp_type   o;
      int                  cl;
      int                  ln;
      int                  best;
      int                  rank;
      chtp_pkg::entry_type e;
      logic [15:0]         mv;
      bit                  weaker;
      o = '0;
      if (r.kind == chtp_pkg::KIND_NEW_SEARCH) begin
         tt_generation = tt_generation + 8'd1;
         if (tt_generation == 8'd0) begin
            tt_generation = 8'd1;
            generation_wraps++;
         end
      end else if (r.kind != chtp_pkg::KIND_UNUSED) begin
         cl = r.cluster_index % chtp_pkg::CLUSTERS;
         ln = -1;
         for (int i = 0; i < chtp_pkg::WAYS; i++)
            if (ln < 0 && tt_entry[cl][i].age != 8'd0 &&
                tt_entry[cl][i].tag == r.key_tag) begin
               ln = i;
               o.hit = 1'b1;
            end
         for (int i = 0; i < chtp_pkg::WAYS; i++)
            if (ln < 0 && tt_entry[cl][i].age == 8'd0) ln = i;
         if (ln < 0) begin
            ln = 0;
            best = replace_rank(tt_entry[cl][0]);
            for (int i = 1; i < chtp_pkg::WAYS; i++) begin
               rank = replace_rank(tt_entry[cl][i]);
               if (rank < best) begin
                  best = rank;
                  ln = i;
               end
            end
            if (r.kind == chtp_pkg::KIND_SAVE) evictions++;
         end
         e = tt_entry[cl][ln];
         o.lane = ln[1:0];
         if (o.hit) begin
            hits_seen++;
            o.found_move  = e.move;
            o.found_score = e.score;
            o.found_eval  = e.eval;
            o.found_depth = e.depth;
            o.found_age   = e.age;
            o.found_bound = e.flag[1:0];
            o.found_pv    = e.flag[2];
         end
         if (r.kind == chtp_pkg::KIND_SAVE) begin
            mv = r.new_move;
            weaker = 1'b0;
            if (o.hit) begin
               weaker = ($signed(r.new_depth) < $signed(e.depth))
                     && (r.new_bound != tt_exact_code)
                     && (e.flag[1:0] == tt_exact_code)
                     && !r.new_pv && e.flag[2];
               if (mv == 16'd0) mv = e.move;
            end
            if (weaker) begin
               saves_skipped++;
            end else begin
               e.tag   = r.key_tag;
               e.move  = mv;
               e.score = r.new_score;
               e.eval  = r.new_eval;
               e.depth = r.new_depth;
               e.age   = tt_generation;
               e.flag  = {r.new_pv, r.new_bound};
               tt_entry[cl][ln] = e;
               o.written = 1'b1;
               entries_written++;
            end
         end
      end
      return o;
   endfunction

   function automatic chtp_pkg::req_type make_item(chtp_pkg::kind_type k, int cl,
                                                   logic [31:0] tag, logic [15:0] mv,
                                                   int sc, int ev, int dp,
                                                   logic [1:0] bd, logic pv);
      chtp_pkg::req_type r;
      r.kind          = k;
      r.cluster_index = cl[11:0];
      r.key_tag       = tag;
      r.new_move      = mv;
      r.new_score     = sc[15:0];
      r.new_eval      = ev[15:0];
      r.new_depth     = dp[15:0];
      r.new_bound     = bd;
      r.new_pv        = pv;
      return r;
   endfunction

   // Mostly hot clusters and pooled tags so that hits and evictions are frequent
   function automatic chtp_pkg::req_type random_item(int search_pct);
      chtp_pkg::req_type r;
      int                roll;
      logic [31:0]       rnd;
      roll = $urandom_range(99);
      if (roll < search_pct) r.kind = chtp_pkg::KIND_NEW_SEARCH;
      else if (roll < search_pct + 4) r.kind = chtp_pkg::KIND_UNUSED;
      else if (roll < search_pct + 4 + (96 - search_pct) * 3 / 5) r.kind = chtp_pkg::KIND_SAVE;
      else r.kind = chtp_pkg::KIND_PROBE;
      rnd = $urandom;
      if ($urandom_range(99) < 85) rnd = hot_cl[$urandom_range(HOT_CLUSTERS - 1)];
      r.cluster_index = rnd[11:0];
      r.key_tag = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(TAG_POOL - 1)] : $urandom;
      rnd = $urandom;
      r.new_move  = ($urandom_range(4) == 0) ? 16'd0 : rnd[15:0];
      r.new_score = rnd[31:16];
      rnd = $urandom;
      r.new_eval  = rnd[15:0];
      if ($urandom_range(9) < 7) rnd = $urandom_range(60) - 20;
      r.new_depth = rnd[31:16];
      if ($urandom_range(9) < 7) r.new_depth = rnd[15:0];
      rnd = $urandom;
      r.new_bound = rnd[1:0];
      r.new_pv    = rnd[2];
      return r;
   endfunction

   function automatic string field_diffs(chtp_pkg::rsp_type got, chtp_pkg::rsp_type exp);
      string s;
      s = "";
      if (got.hit !== exp.hit) s = {s, " hit"};
      if (got.lane !== exp.lane) s = {s, " lane"};
      if (got.found_move !== exp.found_move) s = {s, " found_move"};
      if (got.found_score !== exp.found_score) s = {s, " found_score"};
      if (got.found_eval !== exp.found_eval) s = {s, " found_eval"};
      if (got.found_depth !== exp.found_depth) s = {s, " found_depth"};
      if (got.found_age !== exp.found_age) s = {s, " found_age"};
      if (got.found_bound !== exp.found_bound) s = {s, " found_bound"};
      if (got.found_pv !== exp.found_pv) s = {s, " found_pv"};
      if (got.written !== exp.written) s = {s, " written"};
      return s;
   endfunction

   function automatic string fmt_rsp(chtp_pkg::rsp_type v);
      return $sformatf({"hit=%0b lane=%0d mv=%h sc=%0d ev=%0d dp=%0d age=%0d",
                        " bd=%0d pv=%0b wr=%0b"},
                       v.hit, v.lane, v.found_move, v.found_score, v.found_eval,
                       v.found_depth, v.found_age, v.found_bound, v.found_pv, v.written);
   endfunction

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         rsp_checked++;
         if (lookups_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected response: %s", $time, fmt_rsp(rsp_payload));
         end else begin
            want  = lookups_due.pop_front();
            diffs = field_diffs(rsp_payload, want);
            if (diffs != "") begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] response %0d differs in%s", $time, rsp_checked, diffs);
                  $display("   expected %s", fmt_rsp(want));
                  $display("   actual   %s", fmt_rsp(rsp_payload));
               end
            end
         end
      end
   end

   // Receiver: always ready, or with stalls enabled alternate runs of ready and stalls of random length
   always @(negedge clock) begin
      if (!rsp_stall_en) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (run_left > 0) begin
         rsp_ready <= 1'b1;
         run_left--;
      end else begin
         rsp_ready  <= 1'b1;
         run_left   = $urandom_range(7);
         stall_left = $urandom_range(1, 4);
      end
   end

   task automatic push_request(chtp_pkg::req_type r);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      lookups_due.push_back(probe_table(r));
      items_sent++;
   endtask

   // When idling is enabled and the current burst is used up, end it with a random gap
   task automatic pace_sender();
      int gap;
      if (sender_idle_en) begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_exact_code(logic [1:0] code);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= code;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      tt_exact_code = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      sender_idle_en = 1'b0;
      rsp_stall_en   = 1'b0;
      // empty cluster: tag zero must not hit a never-written lane
      push_request(make_item(chtp_pkg::KIND_PROBE, 0, 32'h0, 16'h0, 0, 0, 0, 2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'hA5A5_0001, 16'h1234, 100, -5, 10,
                             2'd3, 1'b1));
      push_request(make_item(chtp_pkg::KIND_PROBE, 0, 32'hA5A5_0001, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
      // hit with zero move keeps the stored move
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'hA5A5_0001, 16'h0, 200, 7, 20,
                             2'd3, 1'b1));
      // shallower inexact non-pv save over an exact pv entry is dropped
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'hA5A5_0001, 16'h7777, 1, 1, 5,
                             2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'h5A5A_0002, 16'hFFFF, 32767, -32768,
                             32767, 2'd1, 1'b0));
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'h0000_0003, 16'h0001, -32768, 32767,
                             -32768, 2'd2, 1'b1));
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'h0, 16'h0002, 0, 0, 0, 2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_NEW_SEARCH, 0, 32'h0, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_NEW_SEARCH, 0, 32'h0, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
      // full cluster: evict the lowest-ranked lane
      push_request(make_item(chtp_pkg::KIND_SAVE, 0, 32'h0000_0004, 16'h0BAD, 3, 3, 3,
                             2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_PROBE, 0, 32'h0, 16'h0, 0, 0, 0, 2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_PROBE, 0, 32'h0000_0003, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_UNUSED, 4095, 32'hFFFF_FFFF, 16'hFFFF, -1, -1, -1,
                             2'd3, 1'b1));
      push_request(make_item(chtp_pkg::KIND_SAVE, 4095, 32'hFFFF_FFFF, 16'hFFFF, -1, -1, -1,
                             2'd3, 1'b1));
      push_request(make_item(chtp_pkg::KIND_PROBE, 4095, 32'hFFFF_FFFF, 16'hFFFF, -1, -1, -1,
                             2'd3, 1'b1));
      // equal ranks everywhere: the tie goes to lane zero
      for (int i = 1; i <= 5; i++)
         push_request(make_item(chtp_pkg::KIND_SAVE, 5, 32'hC000_0000 + 32'(i),
                                16'(16'h0100 + i), i, i, 7, 2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_PROBE, 5, 32'hC000_0001, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
      push_request(make_item(chtp_pkg::KIND_PROBE, 5, 32'hC000_0005, 16'h0, 0, 0, 0,
                             2'd0, 1'b0));
   endtask

   task automatic test_random_traffic(int count);
      sender_idle_en = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) rsp_stall_en = ($urandom_range(3) != 0);
         push_request(random_item(20));
         pace_sender();
      end
   endtask

   // Heavy on new-search so the generation wraps and age gaps grow large
   task automatic test_generation_wrap(int count);
      sender_idle_en = 1'b1;
      rsp_stall_en   = 1'b1;
      for (int i = 0; i < count; i++) begin
         push_request(random_item(80));
         pace_sender();
      end
   endtask

   task automatic test_back_to_back(int count);
      sender_idle_en = 1'b0;
      rsp_stall_en   = 1'b0;
      for (int i = 0; i < count; i++) push_request(random_item(20));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = 2'd0;
      for (int c = 0; c < chtp_pkg::CLUSTERS; c++)
         for (int w = 0; w < chtp_pkg::WAYS; w++) tt_entry[c][w] = '0;
      tt_generation = 8'd1;
      tt_exact_code = 2'd3;
      hot_cl[0] = 0;
      hot_cl[1] = 5;
      hot_cl[2] = 4095;
      for (int i = 3; i < HOT_CLUSTERS; i++)
         hot_cl[i] = $urandom_range(chtp_pkg::CLUSTERS - 1);
      tag_pool[0] = 32'h0;
      tag_pool[1] = 32'hFFFF_FFFF;
      tag_pool[2] = 32'hA5A5_0001;
      tag_pool[3] = 32'h5A5A_0002;
      for (int i = 4; i < TAG_POOL; i++) tag_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_exact_code(2'd3);
      test_directed_cases();
      set_exact_code(2'd0);
      test_random_traffic(220);
      set_exact_code(2'd2);
      test_random_traffic(200);
      set_exact_code(2'd1);
      test_generation_wrap(260);
      set_exact_code(2'd3);
      test_back_to_back(120);
      test_random_traffic(150);
      wait_drained();

      $display("Sent %0d transactions over four exact-bound settings, checked %0d responses.",
               items_sent, rsp_checked);
      $display("Hits %0d, entries written %0d, saves skipped %0d, evictions %0d, wraps %0d.",
               hits_seen, entries_written, saves_skipped, evictions, generation_wraps);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Timeout with %0d responses outstanding", lookups_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
design/chtp_pkg.sv
design/cluster_hash_table_probe_replace.sv
design/chtp_checker.sv
tb/tb_cluster_hash_table_probe_replace.sv
